### rtl/core/mnmc_pkg.sv
// Shared types and constants for the mesh node mark and compact block.
`timescale 1ns / 1ps

package mnmc_pkg;

    localparam int NODE_W  = 17;           // node id / counter width
    localparam int CFG_W   = 17;           // config write data width
    localparam int PLANE_W = 34;           // dim_i * dim_j
    localparam int ID_W    = 35;           // widest structured corner id
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [3:0] MAX_CORNERS = 4'd8;
    localparam logic [3:0] QUAD_CORNERS = 4'd4;
    localparam logic [3:0] HEX_CORNERS  = 4'd8;

    localparam logic [NODE_W-1:0] SAT17 = {NODE_W{1'b1}};
    localparam logic [31:0]       SAT32 = 32'hFFFF_FFFF;

    // request opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_ELEM  = 2'd1;
    localparam logic [1:0] OP_SCAN  = 2'd2;

    // grid modes
    localparam logic [1:0] MODE_2D = 2'd0;
    localparam logic [1:0] MODE_3D = 2'd1;
    localparam logic [1:0] MODE_EXPLICIT = 2'd2;

    // config register indexes
    localparam logic [1:0] CFG_GRID_MODE = 2'd0;
    localparam logic [1:0] CFG_DIM_I     = 2'd1;
    localparam logic [1:0] CFG_DIM_J     = 2'd2;
    localparam logic [1:0] CFG_TARGET    = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [NODE_W-1:0] dim_i;
        logic [NODE_W-1:0] dim_j;
        logic [15:0]       target;
    } t_cfg;

    typedef enum logic [1:0] {
        K_START  = 2'd0,
        K_MARK   = 2'd1,
        K_SCAN   = 2'd2,
        K_REPORT = 2'd3
    } t_kind;

    // one back-end operation; the node index travels beside it
    typedef struct packed {
        t_kind       kind;
        logic        last;        // final op of a request: emit result
        logic        count_elem;  // element counted at its last op
        logic [3:0]  conn_add;    // corners referenced by the element
        logic        in_range;
        logic [15:0] scan_index;
    } t_uop;

endpackage

### rtl/core/mesh_node_mark_and_compact_top.sv
// Top level of the mesh node mark and compact block: config registers and wiring.
`timescale 1ns / 1ps

// Gathers the distinct nodes used by the elements of one subvolume and hands
// out compacted 1-based numbers while scanning. A request is taken when start
// is high and busy is low; each request gives exactly one result, shown for
// one cycle with o_done, and the receiver cannot stall it. An element request
// that marks n corners (4 in 2D, 8 in 3D, the clamped corner_count in other
// modes) keeps busy high through the prep state and while its corners are
// issued. Start, scan and unused requests, and an element that marks nothing
// (other subvolume or a count of 0), keep busy high through the prep state
// only. The front end issues one corner per cycle, while the op queue is not
// full, into the single-write mark memory. o_done is registered from the last
// op after it passes through the op queue and the back-end op register. After
// reset the mark memory is swept clear, one node per cycle, and busy stays
// high until the sweep ends; config writes are taken during the sweep.
module mesh_node_mark_and_compact_top import mnmc_pkg::*; #(
    parameter int NODES = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic [1:0]         i_op,
    input  logic [15:0]        i_elem_subvolume,
    input  logic [3:0]         i_corner_count,
    input  logic [NODE_W-1:0]  i_node_a,
    input  logic [NODE_W-1:0]  i_node_b,
    input  logic [NODE_W-1:0]  i_node_c,
    input  logic [NODE_W-1:0]  i_node_d,
    input  logic [NODE_W-1:0]  i_node_e,
    input  logic [NODE_W-1:0]  i_node_f,
    input  logic [NODE_W-1:0]  i_node_g,
    input  logic [NODE_W-1:0]  i_node_h,
    input  logic [15:0]        i_scan_index,
    output logic               o_done,
    output logic [31:0]        o_element_total,
    output logic [NODE_W-1:0]  o_unique_nodes,
    output logic [31:0]        o_connection_total,
    output logic [15:0]        o_scanned_node,
    output logic               o_scan_hit,
    output logic [NODE_W-1:0]  o_local_number,
    output logic               o_range_error
);

    localparam int IDX_W = $clog2(NODES);

    t_cfg              r_cfg;
    logic [NODE_W-1:0] node_list [8];

    logic              clearing;
    logic              push, pop, q_full, q_valid;
    t_uop              f_uop, q_uop;
    logic [IDX_W-1:0]  f_idx, q_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= MODE_EXPLICIT;
            r_cfg.dim_i  <= NODE_W'(1);
            r_cfg.dim_j  <= NODE_W'(1);
            r_cfg.target <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_MODE: r_cfg.mode   <= i_cfg_data[1:0];
                CFG_DIM_I:     r_cfg.dim_i  <= i_cfg_data;
                CFG_DIM_J:     r_cfg.dim_j  <= i_cfg_data;
                CFG_TARGET:    r_cfg.target <= i_cfg_data[15:0];
            endcase
        end
    end

    assign node_list[0] = i_node_a;
    assign node_list[1] = i_node_b;
    assign node_list[2] = i_node_c;
    assign node_list[3] = i_node_d;
    assign node_list[4] = i_node_e;
    assign node_list[5] = i_node_f;
    assign node_list[6] = i_node_g;
    assign node_list[7] = i_node_h;

    mnmc_front #(
        .NODES (NODES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_start          (start),
        .o_busy           (busy),
        .i_clearing       (clearing),
        .i_op             (i_op),
        .i_elem_subvolume (i_elem_subvolume),
        .i_corner_count   (i_corner_count),
        .i_node           (node_list),
        .i_scan_index     (i_scan_index),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_uop            (f_uop),
        .o_idx            (f_idx)
    );

    mnmc_queue #(
        .IDX_W (IDX_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_uop   (f_uop),
        .i_idx   (f_idx),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_uop   (q_uop),
        .o_idx   (q_idx)
    );

    mnmc_back #(
        .NODES (NODES)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_uop              (q_uop),
        .i_idx              (q_idx),
        .o_pop              (pop),
        .o_clearing         (clearing),
        .o_done             (o_done),
        .o_element_total    (o_element_total),
        .o_unique_nodes     (o_unique_nodes),
        .o_connection_total (o_connection_total),
        .o_scanned_node     (o_scanned_node),
        .o_scan_hit         (o_scan_hit),
        .o_local_number     (o_local_number),
        .o_range_error      (o_range_error)
    );

endmodule

### rtl/core/mnmc_front.sv
// Front end: accepts requests, derives corner ids and issues back-end ops.
`timescale 1ns / 1ps

module mnmc_front import mnmc_pkg::*; #(
    parameter int NODES = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg                        i_cfg,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_clearing,
    input  logic [1:0]                  i_op,
    input  logic [15:0]                 i_elem_subvolume,
    input  logic [3:0]                  i_corner_count,
    input  logic [NODE_W-1:0]           i_node [8],
    input  logic [15:0]                 i_scan_index,
    input  logic                        i_q_full,
    output logic                        o_push,
    output t_uop                        o_uop,
    output logic [$clog2(NODES)-1:0]    o_idx
);

    localparam int IDX_W = $clog2(NODES);
    localparam logic [ID_W-1:0] NODES_ID = ID_W'(NODES);

    typedef enum logic [2:0] {
        F_IDLE   = 3'b001,
        F_PREP   = 3'b010,
        F_EXPAND = 3'b100
    } t_fstate;

    t_fstate            r_state, n_state;
    logic [1:0]         r_op;
    logic [15:0]        r_sub;
    logic [3:0]         r_cnt;
    logic [NODE_W-1:0]  r_node [8];
    logic [15:0]        r_scan;
    logic               r_struct;
    logic [3:0]         r_n;
    logic [2:0]         r_j;
    logic [ID_W-1:0]    r_base [4];
    logic [PLANE_W-1:0] r_plane;

    logic            accept;
    logic            match;
    logic            structured;
    logic [3:0]      n_count;
    logic            load_base;
    logic            adv_j;
    logic [ID_W-1:0] t_id, r_id, p_id;
    logic [ID_W-1:0] base;
    logic            inc;
    logic [ID_W-1:0] idx_full;
    logic [ID_W-1:0] scan_ext;

    assign o_busy = (r_state != F_IDLE) || i_clearing;
    assign accept = i_start && !o_busy;

    assign match      = (r_op == OP_ELEM) && (r_sub == i_cfg.target);
    assign structured = (i_cfg.mode == MODE_2D) || (i_cfg.mode == MODE_3D);
    assign t_id       = ID_W'(r_node[0]);
    assign r_id       = ID_W'(i_cfg.dim_i);
    assign p_id       = ID_W'(r_plane);
    assign scan_ext   = ID_W'(r_scan);

    always_comb begin
        if (structured) begin
            n_count = (i_cfg.mode == MODE_2D) ? QUAD_CORNERS : HEX_CORNERS;
        end else if (r_cnt > MAX_CORNERS) begin
            n_count = MAX_CORNERS;
        end else begin
            n_count = r_cnt;
        end
    end

    // corner j: bases are t, t+r, t+p, t+p+r; corners 1, 2, 5 and 6 add one; explicit ids pass through
    always_comb begin
        base = t_id;
        inc  = 1'b0;
        if (r_struct) begin
            case (r_j)
                3'd0: begin base = r_base[0]; inc = 1'b0; end
                3'd1: begin base = r_base[0]; inc = 1'b1; end
                3'd2: begin base = r_base[1]; inc = 1'b1; end
                3'd3: begin base = r_base[1]; inc = 1'b0; end
                3'd4: begin base = r_base[2]; inc = 1'b0; end
                3'd5: begin base = r_base[2]; inc = 1'b1; end
                3'd6: begin base = r_base[3]; inc = 1'b1; end
                3'd7: begin base = r_base[3]; inc = 1'b0; end
                default: begin base = r_base[0]; inc = 1'b0; end
            endcase
        end else begin
            base = ID_W'(r_node[r_j]);
        end
    end

    // 0-based index is id - 1, so an increment cancels the decrement
    assign idx_full = inc ? base : base - ID_W'(1);

    always_comb begin
        n_state   = r_state;
        o_push    = 1'b0;
        o_uop     = '0;
        o_idx     = '0;
        load_base = 1'b0;
        adv_j     = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = F_PREP;
                end
            end
            F_PREP: begin
                if (match && n_count != 4'd0) begin
                    load_base = 1'b1;
                    n_state   = F_EXPAND;
                end else if (!i_q_full) begin
                    o_push           = 1'b1;
                    o_uop.last       = 1'b1;
                    o_uop.count_elem = match;
                    o_uop.scan_index = r_scan;
                    o_uop.in_range   = scan_ext < NODES_ID;
                    o_idx            = scan_ext[IDX_W-1:0];
                    if (r_op == OP_START) begin
                        o_uop.kind = K_START;
                    end else if (r_op == OP_SCAN) begin
                        o_uop.kind = K_SCAN;
                    end else begin
                        o_uop.kind = K_REPORT;
                    end
                    n_state = F_IDLE;
                end
            end
            F_EXPAND: begin
                if (!i_q_full) begin
                    o_push           = 1'b1;
                    adv_j            = 1'b1;
                    o_uop.kind       = K_MARK;
                    o_uop.last       = ({1'b0, r_j} == (r_n - 4'd1));
                    o_uop.count_elem = 1'b1;
                    o_uop.conn_add   = r_n;
                    o_uop.in_range   = inc ? (base < NODES_ID)
                                           : ((base != '0) && (base <= NODES_ID));
                    o_idx            = idx_full[IDX_W-1:0];
                    if (o_uop.last) begin
                        n_state = F_IDLE;
                    end
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            if (load_base) begin
                r_j <= '0;
            end else if (adv_j) begin
                r_j <= r_j + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_plane <= PLANE_W'(i_cfg.dim_i) * PLANE_W'(i_cfg.dim_j);
        if (accept) begin
            r_op   <= i_op;
            r_sub  <= i_elem_subvolume;
            r_cnt  <= i_corner_count;
            r_node <= i_node;
            r_scan <= i_scan_index;
        end
        if (load_base) begin
            r_struct  <= structured;
            r_n       <= n_count;
            r_base[0] <= t_id;
            r_base[1] <= t_id + r_id;
            r_base[2] <= t_id + p_id;
            r_base[3] <= t_id + p_id + r_id;
        end
    end

endmodule

### rtl/core/mnmc_queue.sv
// Short op queue between the front end and the mark memory back end.
`timescale 1ns / 1ps

module mnmc_queue import mnmc_pkg::*; #(
    parameter int IDX_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_uop             i_uop,
    input  logic [IDX_W-1:0] i_idx,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output t_uop             o_uop,
    output logic [IDX_W-1:0] o_idx
);

    t_uop               r_uop [Q_DEPTH];
    logic [IDX_W-1:0]   r_idx [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_head, r_tail;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_uop   = r_uop[r_head];
    assign o_idx   = r_idx[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_head <= r_head + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_uop[r_tail] <= i_uop;
            r_idx[r_tail] <= i_idx;
        end
    end

endmodule

### rtl/core/mnmc_back.sv
// Back end: mark memory read-modify-write, counters and result register.
`timescale 1ns / 1ps

module mnmc_back import mnmc_pkg::*; #(
    parameter int NODES = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  t_uop                     i_uop,
    input  logic [$clog2(NODES)-1:0] i_idx,
    output logic                     o_pop,
    output logic                     o_clearing,
    output logic                     o_done,
    output logic [31:0]              o_element_total,
    output logic [NODE_W-1:0]        o_unique_nodes,
    output logic [31:0]              o_connection_total,
    output logic [15:0]              o_scanned_node,
    output logic                     o_scan_hit,
    output logic [NODE_W-1:0]        o_local_number,
    output logic                     o_range_error
);

    localparam int IDX_W = $clog2(NODES);
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(NODES - 1);

    logic             r_mark [NODES];
    logic             r_q;
    logic             r_fwd, r_fwd_val;
    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_addr;

    logic             r_b_valid;
    t_uop             r_b_uop;
    logic [IDX_W-1:0] r_b_idx;

    logic [31:0]       r_elem, n_elem;
    logic [NODE_W-1:0] r_uniq, n_uniq;
    logic [31:0]       r_conn, n_conn;
    logic [NODE_W-1:0] r_comp, n_comp;
    logic              r_rerr, n_rerr;

    logic              r_done;
    logic [31:0]       r_o_elem, r_o_conn;
    logic [NODE_W-1:0] r_o_uniq, r_o_local;
    logic [15:0]       r_o_scanned;
    logic              r_o_hit, r_o_rerr;

    logic              cur;
    logic              b_we, b_wd;
    logic              mark_err, scan_err;
    logic              hit;
    logic [15:0]       scanned;
    logic [NODE_W-1:0] local_num;
    logic [32:0]       conn_sum;
    logic              emit;
    logic              mem_we, mem_wd;
    logic [IDX_W-1:0]  mem_wa;

    assign o_clearing = r_clearing;
    assign o_pop      = i_q_valid && !r_clearing;
    assign cur        = r_fwd ? r_fwd_val : r_q;
    assign conn_sum   = {1'b0, r_conn} + 33'(r_b_uop.conn_add);
    assign emit       = r_b_valid && r_b_uop.last;

    always_comb begin
        n_elem    = r_elem;
        n_uniq    = r_uniq;
        n_conn    = r_conn;
        n_comp    = r_comp;
        b_we      = 1'b0;
        b_wd      = 1'b0;
        mark_err  = 1'b0;
        scan_err  = 1'b0;
        hit       = 1'b0;
        scanned   = '0;
        local_num = '0;
        if (r_b_valid) begin
            case (r_b_uop.kind)
                K_START: begin
                    n_elem = '0;
                    n_uniq = '0;
                    n_conn = '0;
                    n_comp = '0;
                end
                K_MARK: begin
                    if (!r_b_uop.in_range) begin
                        mark_err = 1'b1;
                    end else if (!cur) begin
                        b_we = 1'b1;
                        b_wd = 1'b1;
                        if (r_uniq != SAT17) begin
                            n_uniq = r_uniq + NODE_W'(1);
                        end
                    end
                end
                K_SCAN: begin
                    scanned = r_b_uop.scan_index;
                    if (!r_b_uop.in_range) begin
                        scan_err = 1'b1;
                    end else if (cur) begin
                        b_we = 1'b1;
                        hit  = 1'b1;
                        if (r_comp != SAT17) begin
                            n_comp = r_comp + NODE_W'(1);
                        end
                        local_num = n_comp;
                    end
                end
                default: ;
            endcase
            if (r_b_uop.last && r_b_uop.count_elem) begin
                if (r_elem != SAT32) begin
                    n_elem = r_elem + 32'd1;
                end
                n_conn = conn_sum[32] ? SAT32 : conn_sum[31:0];
            end
        end
    end

    // range error collects over the corner ops of one element
    assign n_rerr = r_rerr | mark_err;

    assign mem_we = r_clearing || b_we;
    assign mem_wa = r_clearing ? r_clr_addr : r_b_idx;
    assign mem_wd = r_clearing ? 1'b0 : b_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mark[mem_wa] <= mem_wd;
        end
        r_q <= r_mark[i_idx];
        // read and write of one address in the same cycle: take the new bit
        r_fwd     <= b_we && (r_b_idx == i_idx);
        r_fwd_val <= b_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_b_valid  <= 1'b0;
            r_elem     <= '0;
            r_uniq     <= '0;
            r_conn     <= '0;
            r_comp     <= '0;
            r_rerr     <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
                if (r_clr_addr == CLR_LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            r_b_valid <= o_pop;
            r_elem    <= n_elem;
            r_uniq    <= n_uniq;
            r_conn    <= n_conn;
            r_comp    <= n_comp;
            if (emit) begin
                r_rerr <= 1'b0;
            end else begin
                r_rerr <= n_rerr;
            end
            r_done <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_uop <= i_uop;
            r_b_idx <= i_idx;
        end
        if (emit) begin
            r_o_elem    <= n_elem;
            r_o_uniq    <= n_uniq;
            r_o_conn    <= n_conn;
            r_o_scanned <= scanned;
            r_o_hit     <= hit;
            r_o_local   <= local_num;
            r_o_rerr    <= n_rerr | scan_err;
        end
    end

    assign o_done             = r_done;
    assign o_element_total    = r_o_elem;
    assign o_unique_nodes     = r_o_uniq;
    assign o_connection_total = r_o_conn;
    assign o_scanned_node     = r_o_scanned;
    assign o_scan_hit         = r_o_hit;
    assign o_local_number     = r_o_local;
    assign o_range_error      = r_o_rerr;

endmodule

### rtl/core/mnmc_checker.sv
// Port-level checks for the mesh node mark and compact block, bound to the top.
`timescale 1ns / 1ps

module mnmc_port_checks import mnmc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input logic              o_scan_hit,
    input logic [NODE_W-1:0] o_local_number,
    input logic              o_range_error
);

    // the clearing sweep holds requests off right after reset
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_done)
        else $error("busy low or result shown right after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_hit_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_scan_hit |-> o_local_number != '0)
        else $error("scan hit without a local number");

    a_miss_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_scan_hit |-> o_local_number == '0)
        else $error("local number given without a scan hit");

    a_hit_vs_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_scan_hit && o_range_error))
        else $error("scan hit and range error in one result");

endmodule

bind mesh_node_mark_and_compact_top mnmc_port_checks u_mnmc_checker (.*);

### verif/mnmc_checker.sv
// Request/result checker for the mesh node mark and compact block.
`timescale 1ns / 1ps

module mnmc_checker import mnmc_pkg::*; #(
    parameter int NODES = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic [1:0]               i_op,
    input  logic [15:0]              i_elem_subvolume,
    input  logic [3:0]               i_corner_count,
    input  logic [7:0][NODE_W-1:0]   i_node_ids,
    input  logic [15:0]              i_scan_index,
    input  logic                     o_done,
    input  logic [31:0]              o_element_total,
    input  logic [NODE_W-1:0]        o_unique_nodes,
    input  logic [31:0]              o_connection_total,
    input  logic [15:0]              o_scanned_node,
    input  logic                     o_scan_hit,
    input  logic [NODE_W-1:0]        o_local_number,
    input  logic                     o_range_error,
    output int                       o_pending,
    output int                       o_failures
);

    typedef struct {
        logic [31:0]       elements;
        logic [NODE_W-1:0] uniques;
        logic [31:0]       connections;
        logic [15:0]       scanned;
        logic              hit;
        logic [NODE_W-1:0] local_no;
        logic              range_err;
    } t_tally;

    bit                marked [NODES];
    logic [31:0]       elem_cnt;
    logic [31:0]       conn_cnt;
    logic [NODE_W-1:0] uniq_cnt;
    logic [NODE_W-1:0] compact_cnt;

    logic [1:0]        grid_mode;
    logic [NODE_W-1:0] row_len;
    logic [NODE_W-1:0] col_len;
    logic [15:0]       target_sv;

    t_tally            tally_q[$];
    int                fails = 0;

    assign o_failures = fails;

    function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [3:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + 33'(b);
        return sum[32] ? SAT32 : sum[31:0];
    endfunction

    // Marks corner ids and scans indices; returns the tally the block should report.
    function automatic t_tally tally_request(input logic [1:0] op, input logic [15:0] sv,
                                             input logic [3:0] ncorners,
                                             input logic [7:0][NODE_W-1:0] ids,
                                             input logic [15:0] idx);
        t_tally      r;
        logic [63:0] corner [8];
        logic [63:0] top;
        logic [63:0] row;
        logic [63:0] plane;
        logic [3:0]  n;
        r = '{default: '0};
        case (op)
            OP_START: begin
                elem_cnt = '0;
                conn_cnt = '0;
                uniq_cnt = '0;
                compact_cnt = '0;
            end
            OP_ELEM: begin
                if (sv == target_sv) begin
                    if (grid_mode == MODE_2D || grid_mode == MODE_3D) begin
                        top = 64'(ids[0]);
                        row = 64'(row_len);
                        plane = 64'(row_len) * 64'(col_len);
                        corner[0] = top;
                        corner[1] = top + 1;
                        corner[2] = top + 1 + row;
                        corner[3] = top + row;
                        for (int j = 0; j < 4; j++) corner[j + 4] = corner[j] + plane;
                        n = (grid_mode == MODE_2D) ? QUAD_CORNERS : HEX_CORNERS;
                    end else begin
                        // undefined mode 3 falls through to explicit lists
                        n = (ncorners > MAX_CORNERS) ? MAX_CORNERS : ncorners;
                        for (int j = 0; j < 8; j++) corner[j] = 64'(ids[j]);
                    end
                    elem_cnt = add_sat32(elem_cnt, 4'd1);
                    for (int j = 0; j < n; j++) begin
                        if (corner[j] >= 64'd1 && corner[j] <= 64'(NODES)) begin
                            if (!marked[int'(corner[j] - 1)]) begin
                                marked[int'(corner[j] - 1)] = 1'b1;
                                if (uniq_cnt != SAT17) uniq_cnt++;
                            end
                        end else begin
                            r.range_err = 1'b1;
                        end
                    end
                    // out-of-range ids still count as connections
                    conn_cnt = add_sat32(conn_cnt, n);
                end
            end
            OP_SCAN: begin
                r.scanned = idx;
                if (int'(idx) < NODES) begin
                    if (marked[idx]) begin
                        marked[idx] = 1'b0;
                        if (compact_cnt != SAT17) compact_cnt++;
                        r.hit = 1'b1;
                        r.local_no = compact_cnt;
                    end
                end else begin
                    r.range_err = 1'b1;
                end
            end
            default: ;
        endcase
        r.elements = elem_cnt;
        r.uniques = uniq_cnt;
        r.connections = conn_cnt;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_tally want;
        if (!i_rst_n) begin
            foreach (marked[k]) marked[k] = 1'b0;
            elem_cnt = '0;
            conn_cnt = '0;
            uniq_cnt = '0;
            compact_cnt = '0;
            grid_mode = MODE_EXPLICIT;
            row_len = NODE_W'(1);
            col_len = NODE_W'(1);
            target_sv = '0;
            tally_q.delete();
        end else begin
            if (o_done) begin
                if (tally_q.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    fails++;
                end else begin
                    want = tally_q.pop_front();
                    check_field("element_total", want.elements, o_element_total);
                    check_field("unique_nodes", 32'(want.uniques), 32'(o_unique_nodes));
                    check_field("connection_total", want.connections, o_connection_total);
                    check_field("scanned_node", 32'(want.scanned), 32'(o_scanned_node));
                    check_field("scan_hit", 32'(want.hit), 32'(o_scan_hit));
                    check_field("local_number", 32'(want.local_no), 32'(o_local_number));
                    check_field("range_error", 32'(want.range_err), 32'(o_range_error));
                end
            end
            if (start && !busy) begin
                tally_q.push_back(tally_request(i_op, i_elem_subvolume, i_corner_count,
                                                i_node_ids, i_scan_index));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRID_MODE: grid_mode = i_cfg_data[1:0];
                    CFG_DIM_I:     row_len = i_cfg_data[NODE_W-1:0];
                    CFG_DIM_J:     col_len = i_cfg_data[NODE_W-1:0];
                    CFG_TARGET:    target_sv = i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        o_pending <= tally_q.size();
    end

endmodule

### verif/testbench.sv
// Top of the mesh node mark and compact testbench: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module testbench;
    import mnmc_pkg::*;

    localparam int NODES = 65536;
    localparam int LIMIT = 1_000_000;
    localparam int SETTLE = 20;
    localparam int PHASE_ITEMS = 125;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] MODE_UNDEFINED = 2'd3;

    typedef struct {
        logic [1:0]              op;
        logic [15:0]             sv;
        logic [3:0]              ncorners;
        logic [7:0][NODE_W-1:0]  ids;
        logic [15:0]             idx;
    } t_request;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [1:0]              i_cfg_idx = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic [1:0]              i_op = '0;
    logic [15:0]             i_elem_subvolume = '0;
    logic [3:0]              i_corner_count = '0;
    logic [7:0][NODE_W-1:0]  node_ids = '0;
    logic [15:0]             i_scan_index = '0;

    logic                    busy;
    logic                    o_done;
    logic [31:0]             o_element_total;
    logic [NODE_W-1:0]       o_unique_nodes;
    logic [31:0]             o_connection_total;
    logic [15:0]             o_scanned_node;
    logic                    o_scan_hit;
    logic [NODE_W-1:0]       o_local_number;
    logic                    o_range_error;

    int                      pending;
    int                      failures;
    int                      cycles = 0;
    int                      sent = 0;
    int                      idle_pct = 0;

    logic [1:0]              cur_mode = MODE_EXPLICIT;
    int                      cur_dim_i = 1;
    int                      cur_dim_j = 1;
    logic [15:0]             cur_target = '0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    mesh_node_mark_and_compact_top #(.NODES(NODES)) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_op               (i_op),
        .i_elem_subvolume   (i_elem_subvolume),
        .i_corner_count     (i_corner_count),
        .i_node_a           (node_ids[0]),
        .i_node_b           (node_ids[1]),
        .i_node_c           (node_ids[2]),
        .i_node_d           (node_ids[3]),
        .i_node_e           (node_ids[4]),
        .i_node_f           (node_ids[5]),
        .i_node_g           (node_ids[6]),
        .i_node_h           (node_ids[7]),
        .i_scan_index       (i_scan_index),
        .o_done             (o_done),
        .o_element_total    (o_element_total),
        .o_unique_nodes     (o_unique_nodes),
        .o_connection_total (o_connection_total),
        .o_scanned_node     (o_scanned_node),
        .o_scan_hit         (o_scan_hit),
        .o_local_number     (o_local_number),
        .o_range_error      (o_range_error)
    );

    mnmc_checker #(.NODES(NODES)) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_op               (i_op),
        .i_elem_subvolume   (i_elem_subvolume),
        .i_corner_count     (i_corner_count),
        .i_node_ids         (node_ids),
        .i_scan_index       (i_scan_index),
        .o_done             (o_done),
        .o_element_total    (o_element_total),
        .o_unique_nodes     (o_unique_nodes),
        .o_connection_total (o_connection_total),
        .o_scanned_node     (o_scanned_node),
        .o_scan_hit         (o_scan_hit),
        .o_local_number     (o_local_number),
        .o_range_error      (o_range_error),
        .o_pending          (pending),
        .o_failures         (failures)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("mesh_node_mark_and_compact_top verification failed");
            $finish;
        end
    end

    // Drives one request, holds it until taken, then idles the sender at random.
    task automatic issue(input t_request rq);
        int gap;
        start <= 1'b1;
        i_op <= rq.op;
        i_elem_subvolume <= rq.sv;
        i_corner_count <= rq.ncorners;
        node_ids <= rq.ids;
        i_scan_index <= rq.idx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
        gap = 0;
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [1:0] mode, input int di, input int dj,
                                input int sv);
        hold_until_drained();
        write_reg(CFG_GRID_MODE, CFG_W'(mode));
        write_reg(CFG_DIM_I, CFG_W'(di));
        write_reg(CFG_DIM_J, CFG_W'(dj));
        write_reg(CFG_TARGET, CFG_W'(sv));
        i_cfg_we <= 1'b0;
        cur_mode = mode;
        cur_dim_i = di;
        cur_dim_j = dj;
        cur_target = 16'(sv);
    endtask

    function automatic t_request make_request(input logic [1:0] op, input int sv, input int cc,
                                              input int a, input int b, input int c,
                                              input int d, input int e, input int f,
                                              input int g, input int h, input int idx);
        t_request rq;
        rq.op = op;
        rq.sv = 16'(sv);
        rq.ncorners = 4'(cc);
        rq.ids[0] = NODE_W'(a);
        rq.ids[1] = NODE_W'(b);
        rq.ids[2] = NODE_W'(c);
        rq.ids[3] = NODE_W'(d);
        rq.ids[4] = NODE_W'(e);
        rq.ids[5] = NODE_W'(f);
        rq.ids[6] = NODE_W'(g);
        rq.ids[7] = NODE_W'(h);
        rq.idx = 16'(idx);
        return rq;
    endfunction

    function automatic t_request random_noise();
        t_request rq;
        rq.op = 2'($urandom_range(3, 0));
        rq.sv = $urandom_range(1, 0) ? cur_target : 16'($urandom);
        rq.ncorners = 4'($urandom);
        for (int j = 0; j < 8; j++) begin
            rq.ids[j] = ($urandom_range(7, 0) == 0) ? NODE_W'(NODES)
                                                    : NODE_W'($urandom_range(NODES, 0));
        end
        rq.idx = 16'($urandom);
        return rq;
    endfunction

    // Element whose ids fall mostly inside the window base+1 .. base+width.
    function automatic t_request random_element(input int base, input int width);
        t_request rq;
        rq = random_noise();
        rq.op = OP_ELEM;
        rq.sv = ($urandom_range(9, 0) == 0) ? 16'($urandom) : cur_target;
        rq.ncorners = ($urandom_range(6, 0) == 0) ? 4'($urandom) : 4'($urandom_range(8, 1));
        for (int j = 0; j < 8; j++) begin
            case ($urandom_range(39, 0))
                0, 1:    rq.ids[j] = '0;
                2:       rq.ids[j] = NODE_W'(NODES);
                default: rq.ids[j] = NODE_W'(base + 1 + $urandom_range(width - 1, 0));
            endcase
        end
        return rq;
    endfunction

    // Start, a few elements in one node window, then a scan across the window.
    task automatic run_sequence();
        longint   span;
        int       width;
        int       scan_len;
        int       base;
        t_request rq;
        span = 0;
        if (cur_mode == MODE_2D) span = 1 + cur_dim_i;
        else if (cur_mode == MODE_3D) span = 1 + cur_dim_i + longint'(cur_dim_i) * cur_dim_j;
        width = $urandom_range(24, 6);
        // corners past a huge stride are only sampled, not swept
        scan_len = width + ((span <= 40) ? int'(span) : 8);
        base = ($urandom_range(7, 0) == 0) ? NODES - scan_len
                                           : $urandom_range(NODES - scan_len, 0);
        rq = random_noise();
        rq.op = OP_START;
        issue(rq);
        repeat ($urandom_range(6, 1)) issue(random_element(base, width));
        for (int k = 0; k < scan_len; k++) begin
            rq = random_noise();
            rq.op = OP_SCAN;
            rq.idx = 16'(base + k);
            issue(rq);
        end
    endtask

    initial begin : stimulus
        int phase_end;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_config(MODE_EXPLICIT, 1, 1, 0);
        issue(make_request(OP_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        issue(make_request(OP_ELEM, 0, 8, 1, 2, 3, NODES, 0, 2, 5, NODES, 0));
        issue(make_request(OP_ELEM, 65535, 8, 30, 31, 32, 33, 34, 35, 36, 37, 0));
        issue(make_request(OP_ELEM, 0, 0, 40, 41, 42, 43, 44, 45, 46, 47, 0));
        issue(make_request(OP_ELEM, 0, 15, 7, 8, 9, 10, 11, 12, 13, 14, 0));
        issue(make_request(OP_ELEM, 0, 9, 7, 8, 9, 10, 11, 12, 13, 15, 0));
        issue(make_request(OP_UNUSED, 0, 3, 50, 51, 52, 0, 0, 0, 0, 0, 77));
        issue(make_request(OP_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        issue(make_request(OP_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65535));
        issue(make_request(OP_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65535));
        issue(make_request(OP_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // marks survive a start, so this one still hits
        issue(make_request(OP_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        issue(make_request(OP_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 12345));

        apply_config(MODE_2D, NODES, 1, 65535);
        issue(make_request(OP_ELEM, 65535, 1, NODES, 0, 0, 0, 0, 0, 0, 0, 0));
        issue(make_request(OP_ELEM, 0, 4, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        issue(make_request(OP_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65535));

        apply_config(MODE_3D, 3, 2, 0);
        issue(make_request(OP_ELEM, 0, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        issue(make_request(OP_ELEM, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        issue(make_request(OP_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        issue(make_request(OP_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        issue(make_request(OP_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4));
        issue(make_request(OP_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10));

        apply_config(MODE_UNDEFINED, NODES, NODES, 0);
        issue(make_request(OP_ELEM, 0, 3, 20, 21, 20, 99, 99, 99, 99, 99, 0));
        issue(make_request(OP_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 19));
        issue(make_request(OP_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 20));

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: apply_config(MODE_EXPLICIT, 1, 1, 0);
                1: apply_config(MODE_2D, 5, 1, 7);
                2: apply_config(MODE_3D, 4, 3, 65535);
                3: apply_config(MODE_UNDEFINED, 2, 9, 1234);
                4: apply_config(MODE_2D, NODES, 1, 0);
                5: apply_config(MODE_3D, 1, NODES, 42);
                6: apply_config(MODE_EXPLICIT, 3, 3, 65535);
                default: apply_config(MODE_3D, NODES, NODES, 0);
            endcase
            // results cannot be held off, so only the sender idles
            idle_pct = (p % 4 == 1) ? 71 : (p % 4 == 3) ? 27 : 0;
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end) begin
                if ($urandom_range(4, 0) == 0) issue(random_noise());
                else run_sequence();
                if ($urandom_range(9, 0) == 0) hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (failures == 0) begin
            $display("mesh_node_mark_and_compact_top verification clean");
        end else begin
            $display("mesh_node_mark_and_compact_top verification failed");
        end
        $finish;
    end

endmodule
